@@ sv/h264rtp_pkg.sv @@
// Package for the H.264 RTP packetizer: the packet descriptor that passes from
// the front to the back, header constants and register indexes. No dependencies.
`default_nettype none

package h264rtp_pkg;

    localparam int MAX_PAYLOAD_W = 12;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;

    localparam logic [7:0] RTP_BYTE0    = 8'h80;
    localparam logic [7:0] MARKER_BIT   = 8'h80;
    localparam logic [7:0] FU_NRI_MASK  = 8'h60;
    localparam logic [7:0] FU_A_TYPE    = 8'd28;
    localparam logic [7:0] FU_TYPE_MASK = 8'h1F;
    localparam logic [7:0] FU_START_BIT = 8'h80;
    localparam logic [7:0] FU_END_BIT   = 8'h40;

    typedef enum logic [1:0] {
        REG_PAYLOAD_TYPE = 2'd0,
        REG_SSRC         = 2'd1,
        REG_MAX_PAYLOAD  = 2'd2,
        REG_INIT_SEQ     = 2'd3
    } cfg_reg_t;

    typedef logic [3:0] byte_idx_t;

    localparam byte_idx_t IDX_VERSION   = 4'd0;
    localparam byte_idx_t IDX_MARKER_PT = 4'd1;
    localparam byte_idx_t IDX_SEQ_HI    = 4'd2;
    localparam byte_idx_t IDX_SEQ_LO    = 4'd3;
    localparam byte_idx_t IDX_TS_3      = 4'd4;
    localparam byte_idx_t IDX_TS_2      = 4'd5;
    localparam byte_idx_t IDX_TS_1      = 4'd6;
    localparam byte_idx_t IDX_TS_0      = 4'd7;
    localparam byte_idx_t IDX_SSRC_3    = 4'd8;
    localparam byte_idx_t IDX_SSRC_2    = 4'd9;
    localparam byte_idx_t IDX_SSRC_1    = 4'd10;
    localparam byte_idx_t IDX_SSRC_0    = 4'd11;
    localparam byte_idx_t IDX_FU_IND    = 4'd12;
    localparam byte_idx_t IDX_FU_HDR    = 4'd13;
    localparam byte_idx_t IDX_PAYLOAD   = 4'd14;

    typedef struct packed {
        logic [7:0]  data;
        logic        eop;
        logic        has_header;
        logic        is_frag;
        logic        marker;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
    } pkt_desc_t;

endpackage

`default_nettype wire

@@ sv/h264rtp_front.sv @@
// Front of the packetizer: accepts NAL bytes, tracks NAL and fragment position
// and builds one packet descriptor per byte that yields output. Uses h264rtp_pkg.
`default_nettype none

module h264rtp_front #(
    parameter int LENGTH_WIDTH = 24
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [7:0]                             s_nal_byte,
    input  wire logic [LENGTH_WIDTH-1:0]                s_nal_length,
    input  wire logic                                   s_last_nal,
    input  wire logic [31:0]                            s_rtp_timestamp,
    input  wire logic [h264rtp_pkg::MAX_PAYLOAD_W-1:0]  max_payload,
    input  wire logic                                   seq_load,
    input  wire logic [15:0]                            seq_value,
    input  wire logic                                   q_full,
    output logic                                        q_push,
    output h264rtp_pkg::pkt_desc_t                      q_desc
);
    import h264rtp_pkg::*;

    localparam int LW = LENGTH_WIDTH;
    localparam int MW = MAX_PAYLOAD_W;

    logic [LW-1:0] pos_reg, pos_next;
    logic [MW-1:0] fill_reg, fill_next;
    logic [7:0]    held_reg, held_next;
    logic          first_reg, first_next;
    logic [15:0]   seq_reg, seq_next;

    logic [LW-1:0] len;
    logic [LW:0]   pos_inc;
    logic          nal_end;
    logic          single;
    logic [MW-1:0] limit;
    logic          frag_end;
    logic [MW-1:0] fill_inc;
    logic          chunk_done;
    logic          pos_zero;
    logic          accept;
    logic          has_header;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        len        = (s_nal_length == '0) ? LW'(1) : s_nal_length;
        pos_inc    = {1'b0, pos_reg} + (LW+1)'(1);
        nal_end    = pos_inc >= {1'b0, len};
        single     = len <= {{(LW-MW){1'b0}}, max_payload};
        limit      = (max_payload > MW'(3)) ? (max_payload - MW'(2)) : MW'(1);
        frag_end   = ({1'b0, pos_reg} + (LW+1)'(limit)) >= {1'b0, len};
        fill_inc   = fill_reg + MW'(1);
        chunk_done = nal_end || (fill_inc >= limit);
        pos_zero   = pos_reg == '0;
        has_header = single ? pos_zero : (fill_reg == '0);
    end

    always_comb begin
        q_push            = accept && (single || !pos_zero);
        q_desc.data       = s_nal_byte;
        q_desc.eop        = single ? nal_end : chunk_done;
        q_desc.has_header = has_header;
        q_desc.is_frag    = !single;
        q_desc.marker     = s_last_nal && (single || frag_end);
        q_desc.seq        = seq_reg;
        q_desc.ts         = s_rtp_timestamp;
        q_desc.fu_ind     = (held_reg & FU_NRI_MASK) | FU_A_TYPE;
        q_desc.fu_hdr     = (held_reg & FU_TYPE_MASK) | (first_reg ? FU_START_BIT : 8'h00)
                            | (frag_end ? FU_END_BIT : 8'h00);
    end

    always_comb begin
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        held_next  = held_reg;
        first_next = first_reg;
        seq_next   = seq_reg;
        if (accept) begin
            if (single) begin
                if (has_header) begin
                    seq_next = seq_reg + 16'd1;
                end
            end else if (pos_zero) begin
                held_next = s_nal_byte;
            end else begin
                if (has_header) begin
                    seq_next   = seq_reg + 16'd1;
                    first_next = 1'b0;
                end
                fill_next = chunk_done ? '0 : fill_inc;
            end
            if (nal_end) begin
                pos_next   = '0;
                fill_next  = '0;
                first_next = 1'b1;
            end else begin
                pos_next = pos_inc[LW-1:0];
            end
        end
        if (seq_load) begin
            seq_next = seq_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            fill_reg  <= '0;
            held_reg  <= '0;
            first_reg <= 1'b1;
            seq_reg   <= '0;
        end else begin
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            held_reg  <= held_next;
            first_reg <= first_next;
            seq_reg   <= seq_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/h264rtp_queue.sv @@
// Short descriptor queue between the front and the back of the packetizer.
// Uses h264rtp_pkg for the descriptor type and depth.
`default_nettype none

module h264rtp_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire h264rtp_pkg::pkt_desc_t push_desc,
    output logic                        full,
    input  wire logic                   pop,
    output h264rtp_pkg::pkt_desc_t      head,
    output logic                        empty
);
    import h264rtp_pkg::*;

    pkt_desc_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? (wr_ptr_reg + QUEUE_AW'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + QUEUE_AW'(1)) : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/h264rtp_back.sv @@
// Back of the packetizer: serialises descriptors into RTP header, FU-A bytes
// and payload through a registered output. Uses h264rtp_pkg.
`default_nettype none

module h264rtp_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_empty,
    input  wire h264rtp_pkg::pkt_desc_t q_head,
    output logic                        q_pop,
    input  wire logic [6:0]             payload_type,
    input  wire logic [31:0]            stream_source_id,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_packet_byte,
    output logic                        m_end_of_packet,
    output logic                        m_last_of_run
);
    import h264rtp_pkg::*;

    byte_idx_t  idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       eop_reg, eop_next;
    logic       last_reg, last_next;

    byte_idx_t  eff_idx;
    logic       load;
    logic       issue;
    logic       at_payload;
    logic [7:0] sel_byte;

    assign eff_idx    = q_head.has_header ? idx_reg : IDX_PAYLOAD;
    assign at_payload = eff_idx == IDX_PAYLOAD;
    assign load       = !valid_reg || m_ready;
    assign issue      = load && !q_empty;
    assign q_pop      = issue && at_payload;

    always_comb begin
        unique case (eff_idx)
            IDX_VERSION:   sel_byte = RTP_BYTE0;
            IDX_MARKER_PT: sel_byte = (q_head.marker ? MARKER_BIT : 8'h00) | {1'b0, payload_type};
            IDX_SEQ_HI:    sel_byte = q_head.seq[15:8];
            IDX_SEQ_LO:    sel_byte = q_head.seq[7:0];
            IDX_TS_3:      sel_byte = q_head.ts[31:24];
            IDX_TS_2:      sel_byte = q_head.ts[23:16];
            IDX_TS_1:      sel_byte = q_head.ts[15:8];
            IDX_TS_0:      sel_byte = q_head.ts[7:0];
            IDX_SSRC_3:    sel_byte = stream_source_id[31:24];
            IDX_SSRC_2:    sel_byte = stream_source_id[23:16];
            IDX_SSRC_1:    sel_byte = stream_source_id[15:8];
            IDX_SSRC_0:    sel_byte = stream_source_id[7:0];
            IDX_FU_IND:    sel_byte = q_head.fu_ind;
            IDX_FU_HDR:    sel_byte = q_head.fu_hdr;
            IDX_PAYLOAD:   sel_byte = q_head.data;
            default:       sel_byte = q_head.data;
        endcase
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        eop_next   = eop_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = !q_empty;
        end
        if (issue) begin
            byte_next = sel_byte;
            eop_next  = at_payload && q_head.eop;
            last_next = at_payload;
            if (at_payload) begin
                idx_next = IDX_VERSION;
            end else if (eff_idx == IDX_SSRC_0) begin
                idx_next = q_head.is_frag ? IDX_FU_IND : IDX_PAYLOAD;
            end else begin
                idx_next = eff_idx + byte_idx_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= IDX_VERSION;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        eop_reg  <= eop_next;
        last_reg <= last_next;
    end

    assign m_valid         = valid_reg;
    assign m_packet_byte   = byte_reg;
    assign m_end_of_packet = eop_reg;
    assign m_last_of_run   = last_reg;

endmodule

`default_nettype wire

@@ sv/h264_rtp_packetizer.sv @@
// Top level of the H.264 RTP packetizer: configuration registers, front,
// descriptor queue and back. Uses h264rtp_pkg and the h264rtp_* modules.
//
// The block takes one NAL byte per cycle while its four-entry descriptor queue
// has room, and sends one packet byte per cycle through a registered output
// while m_ready is high. A byte that continues a packet gives one output byte;
// a byte that opens a packet gives 13 output bytes (RTP header and byte) in
// single NAL mode and 15 in FU-A mode. The held NAL header byte of a fragmented
// NAL gives no output. The user must write the registers through cfg_wr_en,
// cfg_index and cfg_wr_data only while idle; the block does not enforce this.
// Writing initial_sequence loads the sequence counter at once.
`default_nettype none

module h264_rtp_packetizer #(
    parameter int LENGTH_WIDTH = 24
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [31:0]             cfg_wr_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [7:0]              s_nal_byte,
    input  wire logic [LENGTH_WIDTH-1:0] s_nal_length,
    input  wire logic                    s_last_nal,
    input  wire logic [31:0]             s_rtp_timestamp,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [7:0]                   m_packet_byte,
    output logic                         m_end_of_packet,
    output logic                         m_last_of_run
);
    import h264rtp_pkg::*;

    logic [6:0]               payload_type_reg;
    logic [31:0]              ssrc_reg;
    logic [MAX_PAYLOAD_W-1:0] max_payload_reg;
    logic                     seq_load;

    pkt_desc_t push_desc;
    pkt_desc_t head_desc;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;

    assign seq_load = cfg_wr_en && (cfg_reg_t'(cfg_index) == REG_INIT_SEQ);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_type_reg <= 7'd96;
            ssrc_reg         <= '0;
            max_payload_reg  <= MAX_PAYLOAD_W'(1200);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PAYLOAD_TYPE: payload_type_reg <= cfg_wr_data[6:0];
                REG_SSRC:         ssrc_reg         <= cfg_wr_data;
                REG_MAX_PAYLOAD:  max_payload_reg  <= cfg_wr_data[MAX_PAYLOAD_W-1:0];
                REG_INIT_SEQ:     ;
            endcase
        end
    end

    h264rtp_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_nal_byte      (s_nal_byte),
        .s_nal_length    (s_nal_length),
        .s_last_nal      (s_last_nal),
        .s_rtp_timestamp (s_rtp_timestamp),
        .max_payload     (max_payload_reg),
        .seq_load        (seq_load),
        .seq_value       (cfg_wr_data[15:0]),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_desc          (push_desc)
    );

    h264rtp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head_desc),
        .empty     (q_empty)
    );

    h264rtp_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_head           (head_desc),
        .q_pop            (q_pop),
        .payload_type     (payload_type_reg),
        .stream_source_id (ssrc_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packet_byte    (m_packet_byte),
        .m_end_of_packet  (m_end_of_packet),
        .m_last_of_run    (m_last_of_run)
    );

endmodule

`default_nettype wire

@@ sv/h264rtp_checker.sv @@
// Port-level checker for the H.264 RTP packetizer and its bind to the top level.
// Depends only on the port names of h264_rtp_packetizer.
`default_nettype none

module h264rtp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [7:0] s_nal_byte,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_packet_byte,
    input wire logic       m_end_of_packet,
    input wire logic       m_last_of_run
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packet_byte)
            && $stable(m_end_of_packet) && $stable(m_last_of_run))
        else $error("output item changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_packet |-> m_last_of_run)
        else $error("end of packet not on the last output of its input item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_nal_byte))
        else $error("input item withdrawn or changed while waiting");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind h264_rtp_packetizer h264rtp_checker u_checker (.*);

`default_nettype wire
